FILE: sv/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  // Field and register widths
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int IDX_W   = 3;
  localparam int PRESS_W = 24;
  localparam int TEMP_W  = 19;

  // Internal datapath widths
  localparam int DT_W    = 25;  // D2 - C5*256
  localparam int MUL_W   = 42;  // dT times a calibration word
  localparam int DTSQ_W  = 50;  // dT squared
  localparam int T2_W    = 18;  // dT^2 / 2^31
  localparam int SQ_W    = 36;  // squared temperature distances
  localparam int OFF_W   = 40;
  localparam int SENS_W  = 40;
  localparam int SPLIT_W = 20;  // low slice of SENS for the split multiply
  localparam int PLO_W   = RAW_W + SPLIT_W;
  localparam int PHI_W   = RAW_W + 1 + SENS_W - SPLIT_W;
  localparam int PROD_W  = 64;
  localparam int X_W     = 45;  // D1*SENS/2^21 - OFF
  localparam int P_W     = 30;  // P before saturation

  localparam int CORE_STAGES = 7;

  // Register indexes of the configuration port
  typedef enum logic [IDX_W-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_idx_e;

  // Temperature thresholds in 0.01 C
  localparam logic signed [TEMP_W-1:0] T_REF  = TEMP_W'(2000);
  localparam logic signed [TEMP_W-1:0] T_COLD = TEMP_W'(-1500);

  // Range check limits
  localparam logic signed [P_W-1:0]    P_FAIL_LO = P_W'(1000);
  localparam logic signed [P_W-1:0]    P_FAIL_HI = P_W'(120000);
  localparam logic signed [TEMP_W-1:0] T_FAIL_LO = TEMP_W'(-4000);
  localparam logic signed [TEMP_W-1:0] T_FAIL_HI = TEMP_W'(8500);

  // Pressure saturation limits
  localparam logic signed [P_W-1:0] P_SAT_MAX = P_W'(8388607);
  localparam logic signed [P_W-1:0] P_SAT_MIN = P_W'(-8388608);

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // Word leaving the core: full product D1*SENS with its OFF and TEMP
  typedef struct packed {
    logic                     valid;
    logic signed [PROD_W-1:0] prod;
    logic signed [OFF_W-1:0]  off;
    logic signed [TEMP_W-1:0] temp;
  } core_res_t;

endpackage

`default_nettype wire

FILE: sv/bsc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsc_in_if;
  import bsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);

endinterface

`default_nettype wire

FILE: sv/bsc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsc_out_if;
  import bsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PRESS_W-1:0] pressure;
  logic signed [TEMP_W-1:0]  temperature;
  logic                     sensor_fail;

  modport source (output valid, output pressure, output temperature, output sensor_fail,
                  input ready);
  modport sink   (input valid, input pressure, input temperature, input sensor_fail,
                  output ready);

endinterface

`default_nettype wire

FILE: sv/bsc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bsc_pkg::cal_t             cal_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [bsc_pkg::RAW_W-1:0] raw_pressure_i,
  input  wire logic [bsc_pkg::RAW_W-1:0] raw_temperature_i,
  output bsc_pkg::core_res_t             res_o,
  input  wire logic                      res_ready_i
);
  import bsc_pkg::*;

  logic [CORE_STAGES-1:0] vld_q, vld_d, rdy;

  // Stage 0: dT
  logic [RAW_W-1:0]        d1_0_q;
  logic signed [DT_W-1:0]  dt_0_q;
  // Stage 1: products with dT
  logic [RAW_W-1:0]         d1_1_q;
  logic signed [MUL_W-1:0]  p6_1_q, p4_1_q, p3_1_q;
  logic signed [DTSQ_W-1:0] dtsq_1_q;
  // Stage 2: first-order values
  logic [RAW_W-1:0]         d1_2_q;
  logic signed [TEMP_W-1:0] temp_2_q;
  logic signed [OFF_W-1:0]  off_2_q;
  logic signed [SENS_W-1:0] sens_2_q;
  logic [T2_W-1:0]          t2_2_q;
  // Stage 3: squared distances from the thresholds
  logic [RAW_W-1:0]         d1_3_q;
  logic signed [TEMP_W-1:0] temp_3_q;
  logic signed [OFF_W-1:0]  off_3_q;
  logic signed [SENS_W-1:0] sens_3_q;
  logic [T2_W-1:0]          t2_3_q;
  logic [SQ_W-1:0]          dwsq_3_q, dcsq_3_q;
  logic                     warm_3_q, cold_3_q;
  // Stage 4: second-order corrected values
  logic [RAW_W-1:0]         d1_4_q;
  logic signed [TEMP_W-1:0] temp_4_q;
  logic signed [OFF_W-1:0]  off_4_q;
  logic signed [SENS_W-1:0] sens_4_q;
  // Stage 5: split partial products of D1*SENS
  logic [PLO_W-1:0]         plo_5_q;
  logic signed [PHI_W-1:0]  phi_5_q;
  logic signed [TEMP_W-1:0] temp_5_q;
  logic signed [OFF_W-1:0]  off_5_q;
  // Stage 6: full product
  logic signed [PROD_W-1:0] prod_6_q;
  logic signed [TEMP_W-1:0] temp_6_q;
  logic signed [OFF_W-1:0]  off_6_q;

  // Each stage takes a new word when it is empty or its word moves on
  always_comb begin
    rdy[CORE_STAGES-1] = !vld_q[CORE_STAGES-1] || res_ready_i;
    for (int k = CORE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d = vld_q;
    for (int k = 0; k < CORE_STAGES; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Combinational terms of the stages
  logic signed [DT_W-1:0]   dt_d;
  logic signed [MUL_W-1:0]  p6_d, p4_d, p3_d;
  logic signed [DTSQ_W-1:0] dtsq_d;
  logic signed [TEMP_W-1:0] temp_2_d, dw, dc;
  logic signed [OFF_W-1:0]  off_2_d, off_4_d;
  logic signed [SENS_W-1:0] sens_2_d, sens_4_d;
  logic signed [2*TEMP_W-1:0] dwsq_full, dcsq_full;
  logic [X_W-1:0]           off2_dw, off2_dc;
  logic [OFF_W-1:0]         off2;
  logic [SENS_W-1:0]        sens2;
  logic signed [TEMP_W-1:0] temp_4_d;
  logic [PLO_W-1:0]         plo_d;
  logic signed [PHI_W-1:0]  phi_d;
  logic signed [PROD_W-1:0] prod_d;

  always_comb begin
    dt_d   = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.c5, 8'h00});

    p6_d   = dt_0_q * $signed({1'b0, cal_i.c6});
    p4_d   = dt_0_q * $signed({1'b0, cal_i.c4});
    p3_d   = dt_0_q * $signed({1'b0, cal_i.c3});
    dtsq_d = dt_0_q * dt_0_q;

    temp_2_d = $signed(p6_1_q[MUL_W-1:23]) + T_REF;
    off_2_d  = $signed({7'b0, cal_i.c2, 17'b0}) + OFF_W'($signed(p4_1_q[MUL_W-1:6]));
    sens_2_d = $signed({8'b0, cal_i.c1, 16'b0}) + SENS_W'($signed(p3_1_q[MUL_W-1:7]));

    dw        = temp_2_q - T_REF;
    dc        = temp_2_q - T_COLD;
    dwsq_full = dw * dw;
    dcsq_full = dc * dc;

    // Second-order terms; the cold terms only below the lower threshold
    off2_dw = (X_W'(dwsq_3_q) * X_W'(61)) >> 4;
    off2_dc = cold_3_q ? X_W'(dcsq_3_q) * X_W'(15) : '0;
    off2    = OFF_W'(off2_dw + off2_dc);
    sens2   = OFF_W'({dwsq_3_q, 1'b0}) + (cold_3_q ? OFF_W'({dcsq_3_q, 3'b0}) : '0);
    if (warm_3_q) begin
      temp_4_d = temp_3_q;
      off_4_d  = off_3_q;
      sens_4_d = sens_3_q;
    end else begin
      temp_4_d = temp_3_q - $signed({1'b0, t2_3_q});
      off_4_d  = off_3_q - $signed(off2);
      sens_4_d = sens_3_q - $signed(sens2);
    end

    plo_d = d1_4_q * sens_4_q[SPLIT_W-1:0];
    phi_d = $signed({1'b0, d1_4_q}) * $signed(sens_4_q[SENS_W-1:SPLIT_W]);

    prod_d = (PROD_W'(phi_5_q) <<< SPLIT_W) + $signed(PROD_W'(plo_5_q));
  end

  // Payload registers: load whenever the stage may advance
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      d1_0_q <= raw_pressure_i;
      dt_0_q <= dt_d;
    end
    if (rdy[1]) begin
      d1_1_q   <= d1_0_q;
      p6_1_q   <= p6_d;
      p4_1_q   <= p4_d;
      p3_1_q   <= p3_d;
      dtsq_1_q <= dtsq_d;
    end
    if (rdy[2]) begin
      d1_2_q   <= d1_1_q;
      temp_2_q <= temp_2_d;
      off_2_q  <= off_2_d;
      sens_2_q <= sens_2_d;
      t2_2_q   <= dtsq_1_q[31+T2_W-1:31];
    end
    if (rdy[3]) begin
      d1_3_q   <= d1_2_q;
      temp_3_q <= temp_2_q;
      off_3_q  <= off_2_q;
      sens_3_q <= sens_2_q;
      t2_3_q   <= t2_2_q;
      dwsq_3_q <= dwsq_full[SQ_W-1:0];
      dcsq_3_q <= dcsq_full[SQ_W-1:0];
      warm_3_q <= !(temp_2_q < T_REF);
      cold_3_q <= temp_2_q < T_COLD;
    end
    if (rdy[4]) begin
      d1_4_q   <= d1_3_q;
      temp_4_q <= temp_4_d;
      off_4_q  <= off_4_d;
      sens_4_q <= sens_4_d;
    end
    if (rdy[5]) begin
      plo_5_q  <= plo_d;
      phi_5_q  <= phi_d;
      temp_5_q <= temp_4_q;
      off_5_q  <= off_4_q;
    end
    if (rdy[6]) begin
      prod_6_q <= prod_d;
      temp_6_q <= temp_5_q;
      off_6_q  <= off_5_q;
    end
  end

  assign in_ready_o = rdy[0];

  always_comb begin
    res_o.valid = vld_q[CORE_STAGES-1];
    res_o.prod  = prod_6_q;
    res_o.off   = off_6_q;
    res_o.temp  = temp_6_q;
  end

endmodule

`default_nettype wire

FILE: sv/baro_sensor_compensation.sv
// Throughput: one word per cycle while the output takes words; the nine pipeline
// stages each hold a valid bit and advance on their own, so a stall at the output
// only fills empty stages behind it.
// Reset (rst_ni low, asynchronous): all valid bits clear and the six calibration
// registers go to zero; no clearing pass, the block takes words straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  bsc_in_if.sink                         in_i,
  bsc_out_if.source                      out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bsc_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [bsc_pkg::CAL_W-1:0] cfg_data_i
);
  import bsc_pkg::*;

  // Calibration words C1..C6. The user must write them only while the pipeline is
  // empty (the block does not enforce it), so every stage may read them directly.
  cal_t cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_C1:  cal_q.c1 <= cfg_data_i;
        CFG_C2:  cal_q.c2 <= cfg_data_i;
        CFG_C3:  cal_q.c3 <= cfg_data_i;
        CFG_C4:  cal_q.c4 <= cfg_data_i;
        CFG_C5:  cal_q.c5 <= cfg_data_i;
        CFG_C6:  cal_q.c6 <= cfg_data_i;
        default: ;  // drop writes beyond the last register
      endcase
    end
  end

  // Core: dT, first-order terms, second-order correction and the split
  // D1*SENS multiply, seven stages.
  core_res_t core_res;
  logic      core_rdy;
  logic      core_in_rdy;

  bsc_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (cal_q),
    .in_valid_i        (in_i.valid),
    .in_ready_o        (core_in_rdy),
    .raw_pressure_i    (in_i.raw_pressure),
    .raw_temperature_i (in_i.raw_temperature),
    .res_o             (core_res),
    .res_ready_i       (core_rdy)
  );

  assign in_i.ready = core_in_rdy;

  // Stage 8: P = (D1*SENS/2^21 - OFF)/2^15, both shifts floor.
  // Stage 9: range check on the raw values, then saturate into the output word.
  logic                     p_vld_q, out_vld_q;
  logic                     p_rdy, out_rdy;
  logic signed [P_W-1:0]    p_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic signed [X_W-1:0]    x;
  logic signed [PRESS_W-1:0] press_d, press_q;
  logic signed [TEMP_W-1:0]  temp_out_q;
  logic                      fail_d, fail_q;

  assign out_rdy  = !out_vld_q || out_o.ready;
  assign p_rdy    = !p_vld_q || out_rdy;
  assign core_rdy = p_rdy;

  always_comb begin
    x = X_W'($signed(core_res.prod[PROD_W-1:21])) - X_W'(core_res.off);

    fail_d = (p_q < P_FAIL_LO) || (p_q > P_FAIL_HI) ||
             (temp_q < T_FAIL_LO) || (temp_q > T_FAIL_HI);

    // Temperature already fits its 19-bit range; only pressure needs clamping
    if (p_q > P_SAT_MAX) begin
      press_d = PRESS_W'(P_SAT_MAX);
    end else if (p_q < P_SAT_MIN) begin
      press_d = PRESS_W'(P_SAT_MIN);
    end else begin
      press_d = p_q[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (p_rdy) begin
        p_vld_q <= core_res.valid;
      end
      if (out_rdy) begin
        out_vld_q <= p_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy) begin
      p_q    <= x[X_W-1:15];
      temp_q <= core_res.temp;
    end
    if (out_rdy) begin
      press_q    <= press_d;
      temp_out_q <= temp_q;
      fail_q     <= fail_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.pressure    = press_q;
  assign out_o.temperature = temp_out_q;
  assign out_o.sensor_fail = fail_q;

  // A word that passes the range check must lie inside the good window
  a_fail_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.sensor_fail) |->
      (out_o.pressure >= P_FAIL_LO && out_o.pressure <= P_FAIL_HI &&
       out_o.temperature >= T_FAIL_LO && out_o.temperature <= T_FAIL_HI))
    else $error("pass flag on a result outside the good window");

  // Saturated pressure always comes with the fail flag
  a_sat_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.pressure == PRESS_W'(P_SAT_MAX) ||
                     out_o.pressure == PRESS_W'(P_SAT_MIN))) |-> out_o.sensor_fail)
    else $error("saturated pressure without fail flag");

  // The input only stalls when a finished word is held at the output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled with no back-pressure at the output");

endmodule

`default_nettype wire
